/* rtl/isk_pkg.sv */
// Shared types and constants for the indexed stack.
// Used by isk_decode, isk_cell and indexed_stack; depends on nothing else.
package isk_pkg;

   localparam int unsigned DEPTH   = 64;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CMD_W   = 3;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 3'd0,
      CMD_POP       = 3'd1,
      CMD_READ_TOP  = 3'd2,
      CMD_READ_AT   = 3'd3,
      CMD_INSERT_AT = 3'd4,
      CMD_DELETE_AT = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic       ins_en;
      logic       del_en;
      idx_type    pos;
      logic       rd_en;
      idx_type    rpos;
      count_type  count_next;
      status_type status;
   } ctrl_type;

endpackage

/* rtl/indexed_stack.sv */
// Top level of the indexed stack: input register, decoder, row of entry cells
// and result register. Depends on isk_pkg, isk_decode and isk_cell.

// The block accepts one request per cycle while req_stall is low and returns one
// result for each. A request is held in the input register, then decoded,
// executed and answered in a single pass into the result register, which waits
// while the result side stalls; insert and delete shift all 64 entry registers in
// parallel in that same cycle, so every command is a single pass.
module indexed_stack import isk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [IDX_W-1:0]  req_index,
   input  logic [WORD_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_read_value,
   output logic [COUNT_W-1:0] rsp_entry_count,
   output logic              rsp_empty_res,
   output logic [1:0]        rsp_status
);

   logic             req_valid_ff;
   logic [CMD_W-1:0] req_command_ff;
   idx_type          req_index_ff;
   word_type         req_value_ff;

   count_type        count_ff;
   logic             rsp_valid_ff;
   word_type         rsp_read_value_ff;
   count_type        rsp_entry_count_ff;
   logic             rsp_empty_res_ff;
   status_type       rsp_status_ff;

   logic             out_free;
   logic             advance;
   ctrl_type         ctrl;
   word_type         entries [DEPTH];
   word_type         read_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_command_ff <= req_command;
         req_index_ff   <= req_index;
         req_value_ff   <= req_value;
      end
   end

   isk_decode u_decode (
      .command (req_command_ff),
      .index   (req_index_ff),
      .count   (count_ff),
      .ctrl    (ctrl)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      isk_cell #(
         .SLOT (i)
      ) u_cell (
         .clock      (clock),
         .advance    (advance),
         .ctrl       (ctrl),
         .new_word   (req_value_ff),
         .below_word (entries[(i == 0) ? 0 : i - 1]),
         .above_word (entries[(i == DEPTH - 1) ? i : i + 1]),
         .entry      (entries[i])
      );
   end

   always_comb begin
      read_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ctrl.rd_en && (ctrl.rpos == IDX_W'(i))) begin
            read_word = read_word | entries[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            count_ff <= ctrl.count_next;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_value_ff  <= read_word;
         rsp_entry_count_ff <= ctrl.count_next;
         rsp_empty_res_ff   <= (ctrl.count_next == '0);
         rsp_status_ff      <= ctrl.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_empty_res   = rsp_empty_res_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("Entry count exceeds the stack depth.");

   a_count_step: assert property (@(posedge clock)
      !reset |=> (count_ff == $past(count_ff)) ||
                 (count_ff == $past(count_ff) + 1'b1) ||
                 (count_ff == $past(count_ff) - 1'b1))
      else $error("Entry count moved by more than one in a cycle.");

   a_count_hold: assert property (@(posedge clock)
      !reset && !advance |=> $stable(count_ff))
      else $error("Entry count changed without an executed request.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_res_ff == (rsp_entry_count_ff == '0)))
      else $error("Empty flag disagrees with the entry count.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> (rsp_read_value_ff == '0))
      else $error("A failed request returned a nonzero read word.");

endmodule

/* rtl/isk_decode.sv */
// Command decoder: checks a request against the entry count and yields the
// shift, read and count controls plus the status. Depends on isk_pkg.
module isk_decode import isk_pkg::*; (
   input  logic [CMD_W-1:0] command,
   input  idx_type          index,
   input  count_type        count,
   output ctrl_type         ctrl
);

   logic      full;
   logic      empty;
   count_type idx_ext;
   count_type count_inc;
   count_type count_dec;

   assign full      = (count == COUNT_W'(DEPTH));
   assign empty     = (count == '0);
   assign idx_ext   = {1'b0, index};
   assign count_inc = count + 1'b1;
   assign count_dec = count - 1'b1;

   always_comb begin
      ctrl            = '0;
      ctrl.count_next = count;
      ctrl.status     = STATUS_OK;
      case (command_type'(command))
         CMD_PUSH: begin
            if (full) begin
               ctrl.status = STATUS_FULL;
            end else begin
               ctrl.ins_en     = 1'b1;
               ctrl.pos        = count[IDX_W-1:0];
               ctrl.count_next = count_inc;
            end
         end
         CMD_POP: begin
            if (empty) begin
               ctrl.status = STATUS_EMPTY;
            end else begin
               ctrl.count_next = count_dec;
            end
         end
         CMD_READ_TOP: begin
            if (empty) begin
               ctrl.status = STATUS_EMPTY;
            end else begin
               ctrl.rd_en = 1'b1;
               ctrl.rpos  = count_dec[IDX_W-1:0];
            end
         end
         CMD_READ_AT: begin
            if (idx_ext >= count) begin
               ctrl.status = STATUS_RANGE;
            end else begin
               ctrl.rd_en = 1'b1;
               ctrl.rpos  = index;
            end
         end
         CMD_INSERT_AT: begin
            if (idx_ext > count) begin
               ctrl.status = STATUS_RANGE;
            end else if (full) begin
               ctrl.status = STATUS_FULL;
            end else begin
               ctrl.ins_en     = 1'b1;
               ctrl.pos        = index;
               ctrl.count_next = count_inc;
            end
         end
         CMD_DELETE_AT: begin
            if (empty) begin
               ctrl.status = STATUS_EMPTY;
            end else if (idx_ext >= count) begin
               ctrl.status = STATUS_RANGE;
            end else begin
               ctrl.del_en     = 1'b1;
               ctrl.pos        = index;
               ctrl.count_next = count_dec;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* rtl/isk_cell.sv */
// One storage slot of the stack, which loads a new word or a neighbor's word
// when entries shift. Depends on isk_pkg.
module isk_cell import isk_pkg::*; #(
   parameter int unsigned SLOT = 0
) (
   input  logic     clock,
   input  logic     advance,
   input  ctrl_type ctrl,
   input  word_type new_word,
   input  word_type below_word,
   input  word_type above_word,
   output word_type entry
);

   localparam idx_type SLOT_IDX = IDX_W'(SLOT);

   word_type entry_ff;
   word_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en && (SLOT_IDX > ctrl.pos)) begin
         entry_in = below_word;
      end else if (ctrl.ins_en && (SLOT_IDX == ctrl.pos)) begin
         entry_in = new_word;
      end else if (ctrl.del_en && (SLOT_IDX >= ctrl.pos)) begin
         entry_in = above_word;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

/* dv/tb_indexed_stack.sv */
// Self-checking testbench for indexed_stack: directed and random stack commands
// with idling on both channels, checked by a scoreboard that predicts each result.
// Depends on isk_pkg and the indexed_stack RTL.
module tb_indexed_stack;
   timeunit 1ns;
   timeprecision 1ps;
   import isk_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int RSP_HOLD    = 300;
   localparam int TAIL_CYCLES = 10;
   localparam int PHASE_ITEMS = 256;
   localparam int BURST_ITEMS = 96;

   typedef enum int { TREND_GROW, TREND_SHRINK, TREND_MIXED } trend_type;

   class stack_scoreboard;
      typedef struct {
         word_type   read_value;
         count_type  entry_count;
         logic       empty_res;
         status_type status;
      } stack_result_type;

      word_type         words[DEPTH];
      int unsigned      held;
      stack_result_type awaited[$];
      int               errors;
      int               requests;
      int               checked;
      int               status_hits[4];

      function new();
         held = 0;
         errors = 0;
         requests = 0;
         checked = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, idx_type idx, word_type val);
         stack_result_type r;
         int unsigned i;
         r.read_value = '0;
         r.status = STATUS_OK;
         case (cmd)
            CMD_PUSH: begin
               if (held >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  words[held] = val;
                  held++;
               end
            end
            CMD_POP: begin
               if (held == 0) r.status = STATUS_EMPTY;
               else held--;
            end
            CMD_READ_TOP: begin
               if (held == 0) r.status = STATUS_EMPTY;
               else r.read_value = words[held-1];
            end
            CMD_READ_AT: begin
               if (idx >= held) r.status = STATUS_RANGE;
               else r.read_value = words[idx];
            end
            CMD_INSERT_AT: begin
               if (idx > held) begin
                  r.status = STATUS_RANGE;
               end else if (held >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  for (i = held; i > idx; i--) words[i] = words[i-1];
                  words[idx] = val;
                  held++;
               end
            end
            CMD_DELETE_AT: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else if (idx >= held) begin
                  r.status = STATUS_RANGE;
               end else begin
                  for (i = idx; i + 1 < held; i++) words[i] = words[i+1];
                  held--;
               end
            end
            default: begin
            end
         endcase
         r.entry_count = count_type'(held);
         r.empty_res = (held == 0);
         status_hits[r.status]++;
         requests++;
         awaited.push_back(r);
      endfunction

      function void check_result(word_type rv, count_type cnt, logic emp, logic [1:0] st);
         stack_result_type e;
         if (awaited.size() == 0) begin
            $error("result arrived with no request outstanding");
            errors++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (rv !== e.read_value) begin
            $error("read_value: expected %h, got %h", e.read_value, rv);
            errors++;
         end
         if (cnt !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
            errors++;
         end
         if (emp !== e.empty_res) begin
            $error("empty_res: expected %b, got %b", e.empty_res, emp);
            errors++;
         end
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CMD_W-1:0]  req_command = '0;
   logic [IDX_W-1:0]  req_index = '0;
   logic [WORD_W-1:0] req_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic              rsp_empty_res;
   logic [1:0]        rsp_status;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_rsp_cycles = 0;
   int quiet_cycles = 0;

   stack_scoreboard sb = new();

   indexed_stack dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_entry_count(rsp_entry_count),
      .rsp_empty_res(rsp_empty_res),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp_cycles > 0) begin
            n = hold_rsp_cycles;
            hold_rsp_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_read_value, rsp_entry_count, rsp_empty_res, rsp_status);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_indexed_stack: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_indexed_stack: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send(logic [CMD_W-1:0] cmd, idx_type idx, word_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [CMD_W-1:0] pick_command(trend_type trend);
      int w;
      w = $urandom_range(99);
      case (trend)
         TREND_GROW: begin
            if (w < 60) return CMD_PUSH;
            if (w < 85) return CMD_INSERT_AT;
            if (w < 90) return CMD_POP;
            if (w < 95) return CMD_DELETE_AT;
            if (w < 97) return CMD_READ_TOP;
            return CMD_READ_AT;
         end
         TREND_SHRINK: begin
            if (w < 10) return CMD_PUSH;
            if (w < 20) return CMD_INSERT_AT;
            if (w < 55) return CMD_POP;
            if (w < 85) return CMD_DELETE_AT;
            if (w < 90) return CMD_READ_TOP;
            if (w < 98) return CMD_READ_AT;
            return ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
         end
         default: begin
            if (w < 18) return CMD_PUSH;
            if (w < 34) return CMD_INSERT_AT;
            if (w < 50) return CMD_POP;
            if (w < 66) return CMD_DELETE_AT;
            if (w < 80) return CMD_READ_TOP;
            if (w < 97) return CMD_READ_AT;
            return ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
         end
      endcase
   endfunction

   task automatic send_random(trend_type trend);
      logic [CMD_W-1:0] cmd;
      idx_type idx;
      int unsigned top;
      int r;
      cmd = pick_command(trend);
      top = (sb.held > DEPTH - 1) ? DEPTH - 1 : sb.held;
      r = $urandom_range(9);
      if (r < 7) idx = idx_type'($urandom_range(top));
      else if (r == 7) idx = idx_type'(top);
      else if (r == 8) idx = idx_type'((top == 0) ? 0 : top - 1);
      else idx = idx_type'($urandom_range(DEPTH - 1));
      send(cmd, idx, $urandom());
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, bit hold_output);
      trend_type trend;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold_output) hold_rsp_cycles = RSP_HOLD;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         case ((k / BURST_ITEMS) % 3)
            0: trend = TREND_GROW;
            1: trend = TREND_MIXED;
            default: trend = TREND_SHRINK;
         endcase
         send_random(trend);
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(CMD_POP, 0, '0);
      send(CMD_READ_TOP, 0, '0);
      send(CMD_READ_AT, 0, '0);
      send(CMD_DELETE_AT, 0, '0);
      send(CMD_INSERT_AT, 1, 32'h1234_5678);
      send(CMD_INSERT_AT, 0, 32'h0000_0000);
      send(CMD_PUSH, 0, 32'hFFFF_FFFF);
      send(CMD_PUSH, 63, 32'hA5A5_A5A5);
      send(CMD_READ_TOP, 0, '0);
      send(CMD_READ_AT, 0, '0);
      send(CMD_READ_AT, 3, '0);
      send(CMD_READ_AT, 63, '0);
      send(CMD_INSERT_AT, 1, 32'h5A5A_5A5A);
      send(CMD_INSERT_AT, 4, 32'h8000_0001);
      send(CMD_INSERT_AT, 63, 32'h7FFF_FFFE);
      send(CMD_DELETE_AT, 2, '0);
      send(CMD_DELETE_AT, 3, '0);
      send(CMD_SPARE_A, 63, 32'hFFFF_FFFF);
      send(CMD_SPARE_B, 0, '0);
      send(CMD_READ_AT, 1, '0);
      send(CMD_DELETE_AT, 63, '0);
      send(CMD_POP, 0, '0);
      drain();

      run_phase(0, 0, 1'b1);
      run_phase(88, 0, 1'b0);
      run_phase(0, 88, 1'b0);
      run_phase(29, 29, 1'b0);

      rsp_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb_indexed_stack: %0d requests sent, %0d results checked",
               sb.requests, sb.checked);
      $display("tb_indexed_stack: status ok/empty/full/range = %0d/%0d/%0d/%0d",
               sb.status_hits[STATUS_OK], sb.status_hits[STATUS_EMPTY],
               sb.status_hits[STATUS_FULL], sb.status_hits[STATUS_RANGE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_indexed_stack: done, clean");
      end else begin
         $display("tb_indexed_stack: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/isk_pkg.sv
rtl/isk_decode.sv
rtl/isk_cell.sv
rtl/indexed_stack.sv
dv/tb_indexed_stack.sv
